[hw/rtl/assert_macros.svh]
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// implication checked at every edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/pl0sm_pkg.sv]
// types, constants and helpers of the p-machine execute unit
package pl0sm_pkg;

  localparam int STACK_WORDS   = 512;
  localparam int PROGRAM_WORDS = 512;
  localparam int MAX_LEVEL     = 15;
  localparam int ADDR_W = $clog2(STACK_WORDS);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int PC_W   = $clog2(PROGRAM_WORDS);
  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int WORD_W = 32;
  localparam int EXT_W  = WORD_W + 2;
  localparam logic [PC_W-1:0] START_PC_RESET = PC_W'(10);

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  localparam logic [3:0] OPR_RTN = 4'd0;
  localparam logic [3:0] OPR_ADD = 4'd1;
  localparam logic [3:0] OPR_SUB = 4'd2;
  localparam logic [3:0] OPR_MUL = 4'd3;
  localparam logic [3:0] OPR_DIV = 4'd4;
  localparam logic [3:0] OPR_EQL = 4'd5;
  localparam logic [3:0] OPR_NEQ = 4'd6;
  localparam logic [3:0] OPR_LSS = 4'd7;
  localparam logic [3:0] OPR_LEQ = 4'd8;
  localparam logic [3:0] OPR_GTR = 4'd9;
  localparam logic [3:0] OPR_GEQ = 4'd10;
  localparam logic [3:0] OPR_MOD = 4'd11;

  localparam logic [3:0] SYS_OUT  = 4'd1;
  localparam logic [3:0] SYS_READ = 4'd2;
  localparam logic [3:0] SYS_HALT = 4'd3;

  typedef struct packed {
    logic [3:0]        opcode;
    logic [3:0]        level;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
  } in_item_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic [PTR_W-1:0]   frame_base;
    logic [PTR_W-1:0]   stack_top;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic               halted;
    logic               fault;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WALK, S_WALK_WAIT, S_RD, S_RD_WAIT, S_RD2,
    S_CALC, S_DIV, S_EXEC, S_CAL2, S_CAL3, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RA_SP, RA_SP_P1, RA_CHAIN, RA_CHAIN_M, RA_BP_M1, RA_BP_M2
  } rd_sel_t;

  typedef enum logic [2:0] {
    WA_SP_M1, WA_SP_P1, WA_CHAIN_M, WA_SP_M2, WA_SP_M3
  } wr_sel_t;

  typedef enum logic [2:0] {
    WD_M, WD_A, WD_RES, WD_CHAIN, WD_BP, WD_PC3, WD_RV
  } wd_sel_t;

  typedef enum logic [2:0] {
    SP_KEEP, SP_M1, SP_P1, SP_BP_P1, SP_SUB_M
  } sp_sel_t;

  typedef enum logic [1:0] {
    BP_KEEP, BP_A, BP_SP_M1
  } bp_sel_t;

  typedef enum logic [1:0] {
    PC_KEEP, PC_INC, PC_M, PC_RDATA
  } pc_sel_t;

  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    wd_sel_t wd_sel;
    logic    load_chain;
    logic    walk_step;
    logic    load_a;
    logic    load_b;
    logic    calc;
    logic    div_start;
    logic    div_take;
    logic    zero_fault;
    sp_sel_t sp_sel;
    bp_sel_t bp_sel;
    pc_sel_t pc_sel;
    logic    set_ov;
    logic    set_stop;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic       m_small;
    logic [3:0] m_code;
    logic       stopped;
    logic       cnt_zero;
    logic       a_zero;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } status_t;

  // keep 0..STACK_WORDS, otherwise reduce modulo the depth
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic signed [EXT_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p >= 0 && p <= STACK_WORDS) r = p[PTR_W-1:0];
    else r = {1'b0, p[ADDR_W-1:0]};
    return r;
  endfunction

endpackage

[hw/rtl/pl0sm_div.sv]
// iterative signed divider, one quotient bit per cycle
module pl0sm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient,
  output logic signed [31:0] remainder
);
  import pl0sm_pkg::*;

  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] dsr;
  logic [4:0]        cnt;
  logic              busy;
  logic              neg_q;
  logic              neg_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted = {rem[WORD_W-1:0], quo[WORD_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= 5'd31;
      rem   <= '0;
      quo   <= dividend[31] ? 32'(-dividend) : dividend;
      dsr   <= divisor[31] ? 32'(-divisor) : divisor;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (busy) begin
      if (!diff[WORD_W]) begin
        rem <= diff;
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
      if (cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt - 5'd1;
    end
  end

  assign quotient  = neg_q ? 32'(-quo) : quo;
  assign remainder = neg_r ? 32'(-rem[WORD_W-1:0]) : rem[WORD_W-1:0];

endmodule

[hw/rtl/pl0sm_datapath.sv]
// registers, stack memory, alu and result register of the execute unit
module pl0sm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pl0sm_pkg::cmd_t     cmd,
  output pl0sm_pkg::status_t  status,
  input  pl0sm_pkg::in_item_t in_item,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pl0sm_pkg::out_item_t out_item
);
  import pl0sm_pkg::*;

  logic [WORD_W-1:0] mem [STACK_WORDS];
  logic [WORD_W-1:0] rdata;

  logic [PC_W-1:0]    pc;
  logic [PTR_W-1:0]   bp;
  logic [PTR_W-1:0]   sp;
  logic               stopped;
  in_item_t           ins;
  logic [WORD_W-1:0]  chain;
  logic [LVL_W-1:0]   cnt;
  logic signed [31:0] a_reg;
  logic signed [31:0] b_reg;
  logic signed [31:0] res;
  logic               ov;
  logic [WORD_W-1:0]  oval;
  logic               fault;
  logic               out_full;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wd;
  logic [PC_W-1:0]    pc_inc;
  logic signed [EXT_W-1:0] sp_ext;
  logic signed [EXT_W-1:0] bp_ext;
  logic signed [EXT_W-1:0] m_ext;
  logic signed [31:0] alu;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] div_r;

  assign sp_ext = $signed({{(EXT_W-PTR_W){1'b0}}, sp});
  assign bp_ext = $signed({{(EXT_W-PTR_W){1'b0}}, bp});
  assign m_ext  = EXT_W'(ins.operand);
  assign pc_inc = PC_W'(pc + PC_W'(3));

  always_comb begin
    case (cmd.rd_sel)
      RA_SP:      rd_addr = sp[ADDR_W-1:0];
      RA_SP_P1:   rd_addr = sp[ADDR_W-1:0] + ADDR_W'(1);
      RA_CHAIN:   rd_addr = chain[ADDR_W-1:0];
      RA_CHAIN_M: rd_addr = chain[ADDR_W-1:0] - ins.operand[ADDR_W-1:0];
      RA_BP_M1:   rd_addr = bp[ADDR_W-1:0] - ADDR_W'(1);
      RA_BP_M2:   rd_addr = bp[ADDR_W-1:0] - ADDR_W'(2);
      default:    rd_addr = sp[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WA_SP_M1:   wr_addr = sp[ADDR_W-1:0] - ADDR_W'(1);
      WA_SP_P1:   wr_addr = sp[ADDR_W-1:0] + ADDR_W'(1);
      WA_CHAIN_M: wr_addr = chain[ADDR_W-1:0] - ins.operand[ADDR_W-1:0];
      WA_SP_M2:   wr_addr = sp[ADDR_W-1:0] - ADDR_W'(2);
      WA_SP_M3:   wr_addr = sp[ADDR_W-1:0] - ADDR_W'(3);
      default:    wr_addr = sp[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wd_sel)
      WD_M:     wd = ins.operand;
      WD_A:     wd = a_reg;
      WD_RES:   wd = res;
      WD_CHAIN: wd = chain;
      WD_BP:    wd = {{(WORD_W-PTR_W){1'b0}}, bp};
      WD_PC3:   wd = {{(WORD_W-PC_W){1'b0}}, pc_inc};
      WD_RV:    wd = ins.read_value;
      default:  wd = ins.operand;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= mem[rd_addr];
    if (cmd.wr_en) mem[wr_addr] <= wd;
  end

  always_comb begin
    case (ins.operand[3:0])
      OPR_ADD: alu = a_reg + b_reg;
      OPR_SUB: alu = a_reg - b_reg;
      OPR_MUL: alu = a_reg * b_reg;
      OPR_EQL: alu = 32'(a_reg == b_reg);
      OPR_NEQ: alu = 32'(a_reg != b_reg);
      OPR_LSS: alu = 32'(a_reg < b_reg);
      OPR_LEQ: alu = 32'(a_reg <= b_reg);
      OPR_GTR: alu = 32'(a_reg > b_reg);
      OPR_GEQ: alu = 32'(a_reg >= b_reg);
      default: alu = '0;
    endcase
  end

  pl0sm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (a_reg),
    .divisor   (b_reg),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= START_PC_RESET;
      bp       <= PTR_W'(STACK_WORDS - 1);
      sp       <= PTR_W'(STACK_WORDS);
      stopped  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        pc <= cfg_data;
      end
      case (cmd.pc_sel)
        PC_INC:   pc <= pc_inc;
        PC_M:     pc <= ins.operand[PC_W-1:0];
        PC_RDATA: pc <= rdata[PC_W-1:0];
        default:  ;
      endcase
      case (cmd.bp_sel)
        BP_A:     bp <= wrap_ptr(EXT_W'(a_reg));
        BP_SP_M1: bp <= wrap_ptr(sp_ext - EXT_W'(1));
        default:  ;
      endcase
      case (cmd.sp_sel)
        SP_M1:    sp <= wrap_ptr(sp_ext - EXT_W'(1));
        SP_P1:    sp <= wrap_ptr(sp_ext + EXT_W'(1));
        SP_BP_P1: sp <= wrap_ptr(bp_ext + EXT_W'(1));
        SP_SUB_M: sp <= wrap_ptr(sp_ext - m_ext);
        default:  ;
      endcase
      if (cmd.set_stop) stopped <= 1'b1;
      if (cmd.out_load) out_full <= 1'b1;
      else if (!out_stall) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ins   <= in_item;
      ov    <= 1'b0;
      oval  <= '0;
      fault <= 1'b0;
    end
    if (cmd.load_chain) begin
      chain <= {{(WORD_W-PTR_W){1'b0}}, bp};
      cnt   <= ins.level >= 4'(MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : LVL_W'(ins.level);
    end
    if (cmd.walk_step) begin
      chain <= rdata;
      cnt   <= cnt - LVL_W'(1);
    end
    if (cmd.load_a) a_reg <= rdata;
    if (cmd.load_b) b_reg <= rdata;
    if (cmd.calc) res <= alu;
    if (cmd.zero_fault) begin
      res   <= '0;
      fault <= 1'b1;
    end
    if (cmd.div_take) res <= (ins.operand[3:0] == OPR_MOD) ? div_r : div_q;
    if (cmd.set_ov) begin
      ov   <= 1'b1;
      oval <= a_reg;
    end
    if (cmd.out_load) begin
      out_item.next_pc    <= pc;
      out_item.frame_base <= bp;
      out_item.stack_top  <= sp;
      out_item.out_valid  <= ov;
      out_item.out_value  <= oval;
      out_item.halted     <= stopped;
      out_item.fault      <= fault;
    end
  end

  assign out_valid = out_full;

  // load_chain happens in the accept cycle's successor, level taken from the latched item
  always_comb begin
    status.opcode   = ins.opcode;
    status.m_small  = (ins.operand[31:4] == '0);
    status.m_code   = ins.operand[3:0];
    status.stopped  = stopped;
    status.cnt_zero = (cnt == '0);
    status.a_zero   = (a_reg == '0);
    status.b_zero   = (b_reg == '0);
    status.div_done = div_done;
    status.out_free = !out_full || !out_stall;
  end

endmodule

[hw/rtl/pl0sm_ctrl.sv]
// sequencer of the execute unit
module pl0sm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pl0sm_pkg::status_t status,
  output pl0sm_pkg::cmd_t    cmd
);
  import pl0sm_pkg::*;
  `include "assert_macros.svh"

  state_t state;
  state_t state_next;

  logic is_rtn;
  logic is_arith;
  logic is_divmod;
  logic sys_out;
  logic sys_read;
  logic sys_halt;

  assign is_rtn    = status.opcode == OP_OPR && status.m_small && status.m_code == OPR_RTN;
  assign is_arith  = status.opcode == OP_OPR && status.m_small &&
                     status.m_code >= OPR_ADD && status.m_code <= OPR_MOD;
  assign is_divmod = status.m_code == OPR_DIV || status.m_code == OPR_MOD;
  assign sys_out   = status.m_small && status.m_code == SYS_OUT;
  assign sys_read  = status.m_small && status.m_code == SYS_READ;
  assign sys_halt  = status.m_small && status.m_code == SYS_HALT;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (status.stopped) state_next = S_FINISH;
        else if (status.opcode == OP_LOD || status.opcode == OP_STO ||
                 status.opcode == OP_CAL) state_next = S_WALK;
        else if (is_rtn || is_arith || status.opcode == OP_JPC ||
                 (status.opcode == OP_SYS && sys_out)) state_next = S_RD;
        else state_next = S_EXEC;
      end
      S_WALK: begin
        if (!status.cnt_zero) state_next = S_WALK_WAIT;
        else if (status.opcode == OP_CAL) state_next = S_EXEC;
        else state_next = S_RD;
      end
      S_WALK_WAIT: state_next = S_WALK;
      S_RD:        state_next = S_RD_WAIT;
      S_RD_WAIT:   state_next = is_arith ? S_RD2 : S_EXEC;
      S_RD2:       state_next = S_CALC;
      S_CALC:      state_next = (is_divmod && !status.b_zero) ? S_DIV : S_EXEC;
      S_DIV:       if (status.div_done) state_next = S_EXEC;
      S_EXEC:      state_next = (status.opcode == OP_CAL) ? S_CAL2 : S_FINISH;
      S_CAL2:      state_next = S_CAL3;
      S_CAL3:      state_next = S_FINISH;
      S_FINISH:    if (status.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RA_SP;
    cmd.wr_sel = WA_SP_M1;
    cmd.wd_sel = WD_M;
    cmd.sp_sel = SP_KEEP;
    cmd.bp_sel = BP_KEEP;
    cmd.pc_sel = PC_KEEP;
    case (state)
      S_IDLE: cmd.accept = in_valid;
      S_DECODE: begin
        if (!status.stopped && (status.opcode == OP_LOD || status.opcode == OP_STO ||
                                status.opcode == OP_CAL)) cmd.load_chain = 1'b1;
      end
      S_WALK: begin
        if (!status.cnt_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_CHAIN;
        end
      end
      S_WALK_WAIT: cmd.walk_step = 1'b1;
      S_RD: begin
        cmd.rd_en = 1'b1;
        if (status.opcode == OP_LOD) cmd.rd_sel = RA_CHAIN_M;
        else if (is_rtn) cmd.rd_sel = RA_BP_M1;
        else if (is_arith) cmd.rd_sel = RA_SP_P1;
        else cmd.rd_sel = RA_SP;
      end
      S_RD_WAIT: begin
        cmd.load_a = 1'b1;
        if (is_rtn) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_BP_M2;
        end else if (is_arith) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_SP;
        end
      end
      S_RD2: cmd.load_b = 1'b1;
      S_CALC: begin
        if (!is_divmod) cmd.calc = 1'b1;
        else if (status.b_zero) cmd.zero_fault = 1'b1;
        else cmd.div_start = 1'b1;
      end
      S_DIV: cmd.div_take = status.div_done;
      S_EXEC: begin
        cmd.pc_sel = PC_INC;
        case (status.opcode)
          OP_LIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_M;
            cmd.sp_sel = SP_M1;
          end
          OP_OPR: begin
            if (is_rtn) begin
              cmd.pc_sel = PC_RDATA;
              cmd.bp_sel = BP_A;
              cmd.sp_sel = SP_BP_P1;
            end else if (is_arith) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WA_SP_P1;
              cmd.wd_sel = WD_RES;
              cmd.sp_sel = SP_P1;
            end
          end
          OP_LOD: begin
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_A;
            cmd.sp_sel = SP_M1;
          end
          OP_STO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WA_CHAIN_M;
            cmd.wd_sel = WD_A;
            cmd.sp_sel = SP_P1;
          end
          OP_CAL: begin
            // static link first, pointers move on the last write
            cmd.pc_sel = PC_KEEP;
            cmd.wr_en  = 1'b1;
            cmd.wd_sel = WD_CHAIN;
          end
          OP_INC: cmd.sp_sel = SP_SUB_M;
          OP_JMP: cmd.pc_sel = PC_M;
          OP_JPC: begin
            cmd.pc_sel = status.a_zero ? PC_M : PC_INC;
            cmd.sp_sel = SP_P1;
          end
          OP_SYS: begin
            if (sys_out) begin
              cmd.set_ov = 1'b1;
              cmd.sp_sel = SP_P1;
            end else if (sys_read) begin
              cmd.wr_en  = 1'b1;
              cmd.wd_sel = WD_RV;
              cmd.sp_sel = SP_M1;
            end else if (sys_halt) begin
              cmd.set_stop = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_CAL2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_SP_M2;
        cmd.wd_sel = WD_BP;
      end
      S_CAL3: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WA_SP_M3;
        cmd.wd_sel = WD_PC3;
        cmd.bp_sel = BP_SP_M1;
        cmd.pc_sel = PC_M;
      end
      S_FINISH: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  `ASSERT_IMPLY(a_halt_no_write, clk, rst, status.stopped && state != S_EXEC, !cmd.wr_en)
  `ASSERT_IMPLY(a_load_free, clk, rst, cmd.out_load, status.out_free)
  `ASSERT_ALWAYS(a_rd_wr_apart, clk, rst, !(cmd.rd_en && cmd.wr_en))
  `ASSERT_NEXT(a_finish_done, clk, rst, state == S_FINISH && status.out_free, state == S_IDLE)

endmodule

[hw/rtl/pl0_stack_machine_execute_top.sv]
// top level of the p-machine execute unit
//
// in_item carries one decoded instruction (opcode, level, operand, read value)
// and is taken when in_valid is high and in_stall low. each item gives exactly
// one out_item with the pc, base and stack pointers after it, the output value
// of a sys output call, the halt flag and the divide-by-zero fault.
// lit, inc, jmp, sys read, sys halt and unknown codes go straight to execute;
// jpc, sys output and rtn first read the stack, add to geq read both operands
// and then compute, and lod, sto and cal first walk one static link per level;
// div and mod with a nonzero divisor wait on the divider, one quotient bit per
// cycle, and skip it with a zero one. the stack memory has a registered read.
// one item is in work at a time; the next is taken while the last result still
// waits in the output register. while out_stall is high the result holds and
// the unit stops in its last step until the register frees. reset sets pc to
// 10 (START_PC_RESET), bp to 511, sp to 512 and clears the halt flag; the stack
// memory is not cleared. cfg_we loads the pc from cfg_data. after halt items
// are taken but only report the current pointers.
module pl0_stack_machine_execute_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pl0sm_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pl0sm_pkg::out_item_t out_item,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data
);
  import pl0sm_pkg::*;

  cmd_t    cmd;
  status_t status;

  pl0sm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pl0sm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[tb/tb_pl0_stack_machine_execute_top.sv]
// self-checking testbench for the p-machine execute unit
module tb_pl0_stack_machine_execute_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pl0sm_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CFG_SETTLE     = 80;

  typedef struct {
    bit             is_cfg;
    logic [8:0]     start;
    in_item_t       instr;
  } feed_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_we;
  logic [8:0] cfg_data;

  pl0_stack_machine_execute_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // two machine copies: 0 plans legal programs, 1 follows what the dut accepts
  logic [31:0] stk [2][STACK_WORDS];
  bit          stk_set [2][STACK_WORDS];
  longint      pc_r [2];
  longint      bp_r [2];
  longint      sp_r [2];
  bit          halt_r [2];
  bit          bad_rd;

  feed_t     feed [$];
  out_item_t expected_state [$];
  int        errors;
  int        results_seen;
  bit        feed_done;

  function automatic longint word_idx(longint a);
    longint r;
    r = a % STACK_WORDS;
    if (r < 0) r += STACK_WORDS;
    return r;
  endfunction

  function automatic longint ptr_wrap(longint p);
    if (p >= 0 && p <= STACK_WORDS) return p;
    return word_idx(p);
  endfunction

  function automatic longint pc_wrap(longint p);
    longint r;
    r = p % PROGRAM_WORDS;
    if (r < 0) r += PROGRAM_WORDS;
    return r;
  endfunction

  function automatic longint peek(int k, longint a);
    longint i;
    logic signed [31:0] w;
    i = word_idx(a);
    if (!stk_set[k][i]) bad_rd = 1;
    w = stk[k][i];
    return longint'(w);
  endfunction

  function automatic void poke(int k, longint a, longint v, bit commit);
    longint i;
    i = word_idx(a);
    if (commit) begin
      stk[k][i] = v[31:0];
      stk_set[k][i] = 1;
    end
  endfunction

  function automatic longint follow_links(int k, logic [3:0] lv);
    longint b;
    int n;
    b = bp_r[k];
    n = (lv > MAX_LEVEL) ? MAX_LEVEL : lv;
    repeat (n) b = peek(k, b);
    return b;
  endfunction

  // executes one instruction on machine k; without commit only the reads happen
  function automatic out_item_t execute(int k, in_item_t it, bit commit);
    longint sp, bp, pc, m, a, b, r, v, sl;
    bit ov, flt;
    logic [31:0] oval;
    out_item_t o;
    sp = sp_r[k]; bp = bp_r[k]; pc = pc_r[k];
    m = longint'(it.operand);
    ov = 0; flt = 0; oval = '0;
    if (!halt_r[k]) begin
      pc = pc_r[k] + 3;
      case (it.opcode)
        OP_LIT: begin
          sp = sp - 1;
          poke(k, sp, m, commit);
        end
        OP_OPR: begin
          if (m == longint'(OPR_RTN)) begin
            sp = bp + 1;
            bp = ptr_wrap(peek(k, sp - 2));
            pc = peek(k, sp - 3);
          end else if (m >= 1 && m <= 11) begin
            a = peek(k, sp + 1);
            b = peek(k, sp);
            r = 0;
            case (m[3:0])
              OPR_ADD: r = a + b;
              OPR_SUB: r = a - b;
              OPR_MUL: r = a * b;
              OPR_DIV: if (b == 0) flt = 1; else r = a / b;
              OPR_EQL: r = (a == b);
              OPR_NEQ: r = (a != b);
              OPR_LSS: r = (a < b);
              OPR_LEQ: r = (a <= b);
              OPR_GTR: r = (a > b);
              OPR_GEQ: r = (a >= b);
              default: if (b == 0) flt = 1; else r = a % b;
            endcase
            poke(k, sp + 1, r, commit);
            sp = sp + 1;
          end
        end
        OP_LOD: begin
          v = peek(k, follow_links(k, it.level) - m);
          sp = sp - 1;
          poke(k, sp, v, commit);
        end
        OP_STO: begin
          a = follow_links(k, it.level) - m;
          poke(k, a, peek(k, sp), commit);
          sp = sp + 1;
        end
        OP_CAL: begin
          sl = follow_links(k, it.level);
          poke(k, sp - 1, sl, commit);
          poke(k, sp - 2, bp, commit);
          poke(k, sp - 3, pc_wrap(pc), commit);
          bp = sp - 1;
          pc = m;
        end
        OP_INC: sp = sp - m;
        OP_JMP: pc = m;
        OP_JPC: begin
          if (peek(k, sp) == 0) pc = m;
          sp = sp + 1;
        end
        OP_SYS: begin
          if (m == longint'(SYS_OUT)) begin
            ov = 1;
            oval = peek(k, sp);
            sp = sp + 1;
          end else if (m == longint'(SYS_READ)) begin
            sp = sp - 1;
            poke(k, sp, longint'(it.read_value), commit);
          end else if (m == longint'(SYS_HALT) && commit) begin
            halt_r[k] = 1;
          end
        end
        default: ;
      endcase
      if (commit) begin
        pc_r[k] = pc_wrap(pc);
        bp_r[k] = ptr_wrap(bp);
        sp_r[k] = ptr_wrap(sp);
      end
    end
    o.next_pc    = pc_r[k][PC_W-1:0];
    o.frame_base = bp_r[k][PTR_W-1:0];
    o.stack_top  = sp_r[k][PTR_W-1:0];
    o.out_valid  = ov;
    o.out_value  = oval;
    o.halted     = halt_r[k];
    o.fault      = flt;
    return o;
  endfunction

  // queues the instruction only if it reads no unwritten stack word
  function automatic bit offer(logic [3:0] op, logic [3:0] lv, longint m, longint rv);
    feed_t f;
    out_item_t o;
    f.is_cfg = 0;
    f.start = '0;
    f.instr.opcode = op;
    f.instr.level = lv;
    f.instr.operand = m[31:0];
    f.instr.read_value = rv[31:0];
    bad_rd = 0;
    o = execute(0, f.instr, 0);
    if (bad_rd) return 0;
    o = execute(0, f.instr, 1);
    feed.push_back(f);
    return 1;
  endfunction

  function automatic void queue_start(logic [8:0] v);
    feed_t f;
    f.is_cfg = 1;
    f.start = v;
    f.instr = '0;
    pc_r[0] = v;
    feed.push_back(f);
  endfunction

  function automatic longint any_word();
    return longint'($signed($urandom()));
  endfunction

  function automatic bit random_instr();
    int pick;
    logic [3:0] op, lv;
    longint m;
    pick = $urandom_range(0, 99);
    lv = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    m = $urandom_range(0, 7) - 3;
    if (pick < 24) begin
      op = OP_LIT;
      m = ($urandom_range(0, 2) == 0) ? any_word() : longint'($urandom_range(0, 20)) - 10;
    end else if (pick < 44) begin
      op = OP_OPR;
      m = $urandom_range(0, 11);
      if ($urandom_range(0, 30) == 0) m = any_word();
    end else if (pick < 56) op = OP_LOD;
    else if (pick < 66) op = OP_STO;
    else if (pick < 71) begin
      op = OP_CAL;
      m = $urandom_range(0, 511);
    end else if (pick < 76) op = OP_INC;
    else if (pick < 80) begin
      op = OP_JMP;
      m = any_word();
    end else if (pick < 86) begin
      op = OP_JPC;
      m = any_word();
    end else if (pick < 96) begin
      op = OP_SYS;
      m = ($urandom_range(0, 3) == 0) ? any_word() : longint'($urandom_range(0, 5));
      if (m == longint'(SYS_HALT)) m = SYS_OUT;
    end else begin
      op = 4'($urandom_range(10, 15));
      if ($urandom_range(0, 1) == 0) op = 4'd0;
      m = any_word();
    end
    if ($urandom_range(0, 20) == 0) m = any_word();
    return offer(op, lv, m, any_word());
  endfunction

  task automatic flag(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int gap, settle, burst;
  always @(posedge clk) begin
    feed_t f;
    bit cfg_fire;
    cfg_fire = 0;
    if (rst) begin
      in_valid <= 0;
      in_item <= '0;
      cfg_data <= '0;
      gap = 0;
      settle = 0;
      burst = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_state.push_back(execute(1, in_item, 1));
        if (burst > 0) begin
          burst--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 10);
          if ($urandom_range(0, 40) == 0) burst = $urandom_range(20, 60);
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (feed.size() > 0 && feed[0].is_cfg) begin
          in_valid <= 0;
          if (expected_state.size() == 0) begin
            settle++;
            if (settle >= CFG_SETTLE) begin
              f = feed.pop_front();
              cfg_fire = 1;
              cfg_data <= f.start;
              pc_r[1] = f.start;
              settle = 0;
            end
          end
        end else if (feed.size() > 0) begin
          f = feed.pop_front();
          in_item <= f.instr;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
    cfg_we <= cfg_fire;
  end

  // monitor and receiver stalls
  int hold;
  bit long_hold_done;
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      out_stall <= 0;
      hold = 0;
      long_hold_done = 0;
    end else begin
      if (hold > 0) hold--;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_state.size() == 0) begin
          flag("result item with nothing expected");
        end else begin
          e = expected_state.pop_front();
          if (out_item.next_pc !== e.next_pc)
            flag($sformatf("next_pc %0d, want %0d", out_item.next_pc, e.next_pc));
          if (out_item.frame_base !== e.frame_base)
            flag($sformatf("frame_base %0d, want %0d", out_item.frame_base, e.frame_base));
          if (out_item.stack_top !== e.stack_top)
            flag($sformatf("stack_top %0d, want %0d", out_item.stack_top, e.stack_top));
          if (out_item.out_valid !== e.out_valid)
            flag($sformatf("out_valid %0b, want %0b", out_item.out_valid, e.out_valid));
          if (out_item.out_value !== e.out_value)
            flag($sformatf("out_value %0d, want %0d", out_item.out_value, e.out_value));
          if (out_item.halted !== e.halted)
            flag($sformatf("halted %0b, want %0b", out_item.halted, e.halted));
          if (out_item.fault !== e.fault)
            flag($sformatf("fault %0b, want %0b", out_item.fault, e.fault));
        end
        // no stalls for a stretch, one long hold-off, otherwise random waits
        if (results_seen >= 400 && results_seen < 480) hold = 0;
        else if (results_seen == 300 && !long_hold_done) begin
          hold = 400;
          long_hold_done = 1;
        end else hold = $urandom_range(0, 10);
      end
      out_stall <= (hold > 0);
    end
  end

  // watchdog on cycles with no progress
  int quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n;
    bit ok;
    logic [8:0] starts [5];
    errors = 0;
    results_seen = 0;
    feed_done = 0;
    rst = 1;
    in_valid = 0;
    in_item = '0;
    out_stall = 0;
    cfg_we = 0;
    cfg_data = '0;
    for (int k = 0; k < 2; k++) begin
      pc_r[k] = START_PC_RESET;
      bp_r[k] = STACK_WORDS - 1;
      sp_r[k] = STACK_WORDS;
      halt_r[k] = 0;
      for (int i = 0; i < STACK_WORDS; i++) stk_set[k][i] = 0;
    end

    // top word points to itself, so every static chain walk stays defined
    ok = offer(OP_LIT, 0, 511, 0);
    ok = offer(OP_LIT, 0, 32'h7fffffff, 0);
    ok = offer(OP_LIT, 0, 32'h7fffffff, 0);
    ok = offer(OP_OPR, 0, OPR_ADD, 0);
    ok = offer(OP_LIT, 0, 0, 0);
    ok = offer(OP_OPR, 0, OPR_DIV, 0);
    ok = offer(OP_LIT, 0, -64'sd2147483648, 0);
    ok = offer(OP_LIT, 0, -1, 0);
    ok = offer(OP_OPR, 0, OPR_DIV, 0);
    ok = offer(OP_LIT, 0, -1, 0);
    ok = offer(OP_OPR, 0, OPR_MOD, 0);
    ok = offer(OP_LIT, 0, 0, 0);
    ok = offer(OP_OPR, 0, OPR_MOD, 0);
    ok = offer(OP_CAL, 15, 32'h7fffffff, 0);
    ok = offer(OP_LOD, 15, 0, 0);
    ok = offer(OP_STO, 15, -1, 0);
    ok = offer(OP_SYS, 0, SYS_READ, -64'sd2147483648);
    ok = offer(OP_SYS, 0, SYS_OUT, 0);
    ok = offer(OP_INC, 0, -64'sd2147483648, 0);
    ok = offer(OP_INC, 0, 32'h7fffffff, 0);
    ok = offer(OP_JPC, 0, -1, 0);
    ok = offer(OP_JMP, 0, 32'h7fffffff, 0);
    ok = offer(4'd15, 15, -1, -1);
    ok = offer(OP_OPR, 0, 12, 0);
    ok = offer(OP_SYS, 0, 32'h7fffffff, 0);

    starts[0] = 9'd0;
    starts[1] = 9'd511;
    starts[2] = 9'($urandom_range(0, 511));
    starts[3] = 9'd1;
    starts[4] = 9'($urandom_range(0, 511));
    n = 0;
    while (n < 750) begin
      if (n % 150 == 0) queue_start(starts[n / 150]);
      if (random_instr()) n++;
    end
    ok = offer(OP_SYS, 0, SYS_HALT, 0);
    repeat (4) ok = random_instr();

    repeat (8) @(posedge clk);
    rst <= 0;
    while (feed.size() > 0 || in_valid || expected_state.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_state.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
